// ===== hdl/min_squares_sum_count_assert.svh =====
// assertion macros used by the sequencer's checks
`ifndef MIN_SQUARES_SUM_COUNT_ASSERT_SVH
`define MIN_SQUARES_SUM_COUNT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MSQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MSQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/msq_pkg.sv =====
// shared types and constants of the square count block
package msq_pkg;

	// largest target handled
	localparam int MAX_N = 4096;
	// width of the target field
	localparam int TW = 13;
	// width of the result field
	localparam int RW = 3;
	// width that holds 0..MAX_N
	localparam int NW = $clog2(MAX_N + 1);
	// table address width
	localparam int AW = $clog2(MAX_N);
	// running square, one step past the row index
	localparam int JW = NW + 1;
	// odd increment between squares
	localparam int OW = NW / 2 + 3;
	// width for the clamp compare
	localparam int CW = (NW > TW) ? NW : TW;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_WRITE = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	// table access from the sequencer
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [RW-1:0] wdata;
		logic          re;
		logic [AW-1:0] raddr;
	} tbl_req_t;

	// clamp a target into 1..MAX_N
	function automatic logic [NW-1:0] clamp_target(input logic [TW-1:0] t);
		logic [CW-1:0] tx;
		tx = CW'(t);
		if (tx == '0)
			return NW'(1);
		else if (tx > CW'(MAX_N))
			return NW'(MAX_N);
		else
			return tx[NW-1:0];
	endfunction

endpackage

// ===== hdl/msq_table.sv =====
// count table memory, one write and one registered read port
module msq_table (
	input  logic                      clk,
	input  msq_pkg::tbl_req_t         req,
	output logic [msq_pkg::RW-1:0]    rdata
);
	import msq_pkg::*;

	logic [RW-1:0] mem [MAX_N];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ===== hdl/msq_seq.sv =====
// row and square sequencer that fills the table and returns the count
module msq_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [msq_pkg::TW-1:0] in_target,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [msq_pkg::RW-1:0] out_count,
	output msq_pkg::tbl_req_t      req,
	input  logic [msq_pkg::RW-1:0] rdata
);
	import msq_pkg::*;

	state_t        state_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] i_q;
	logic [JW-1:0] jsq_q;
	logic [OW-1:0] odd_q;
	logic [RW-1:0] best_q;
	logic          rd_pend_q;
	logic [RW-1:0] res_q;
	logic          out_valid_q;
	logic [RW-1:0] out_count_q;

	logic          in_fire;
	logic          scan_more;
	logic [RW-1:0] best_upd;
	logic [RW-1:0] row_val;
	logic [JW-1:0] rd_diff;
	logic          out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_count = out_count_q;
	assign out_free  = !out_valid_q || out_ready;

	// scan continues while j*j is below the row index
	assign scan_more = (state_q == S_SCAN) && (jsq_q < JW'(i_q));
	assign rd_diff   = JW'(i_q) - jsq_q - JW'(1);

	// fold in the read that returned this cycle
	always_comb begin
		best_upd = best_q;
		if (rd_pend_q && (rdata < best_q)) begin
			best_upd = rdata;
		end
	end

	// value stored for the row: one for a square, else best plus one
	assign row_val = (jsq_q == JW'(i_q)) ? RW'(1) : RW'(best_q + RW'(1));

	// table requests
	always_comb begin
		req.re    = scan_more;
		req.raddr = rd_diff[AW-1:0];
		req.we    = (state_q == S_WRITE);
		req.waddr = AW'(i_q - NW'(1));
		req.wdata = row_val;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rd_pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_pend_q <= scan_more;
					if (!scan_more) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= (i_q == n_q) ? S_DONE : S_SCAN;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// row counters and running minimum
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				n_q    <= clamp_target(in_target);
				i_q    <= NW'(1);
				jsq_q  <= JW'(1);
				odd_q  <= OW'(3);
				best_q <= '1;
			end
			S_SCAN: begin
				best_q <= best_upd;
				if (scan_more) begin
					jsq_q <= jsq_q + JW'(odd_q);
					odd_q <= odd_q + OW'(2);
				end
			end
			S_WRITE: begin
				res_q  <= row_val;
				i_q    <= i_q + NW'(1);
				jsq_q  <= JW'(1);
				odd_q  <= OW'(3);
				best_q <= '1;
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_count_q <= res_q;
		end
	end

`include "min_squares_sum_count_assert.svh"

	`MSQ_ASSERT_NOW(a_pend_in_scan, rd_pend_q, state_q == S_SCAN, "read pending outside scan")
	`MSQ_ASSERT_NOW(a_read_below_row, req.re, JW'(req.raddr) < JW'(i_q - NW'(1)), "read at or past row")
	`MSQ_ASSERT_NOW(a_row_in_range, (state_q == S_SCAN) || (state_q == S_WRITE), (i_q != '0) && (i_q <= n_q), "row out of range")
	`MSQ_ASSERT_NEXT(a_start_scan, in_fire, state_q == S_SCAN, "accepted target did not start scan")

endmodule

// ===== hdl/min_squares_sum_count.sv =====
// Minimum perfect-squares count: each transaction on s_ carries a target N, which is clamped
// into 1..4096, and one transaction on m_ returns the least number of squares summing to N
// (1 to 4). The count table is rebuilt from row 1 to row N in a single-port-read memory:
// row i does one table read per square below i, one read per cycle, then writes its count.
// A new target is taken once the previous result sits in the output register.
module min_squares_sum_count (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [12:0] target, [15:13] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [2:0] square_count, [7:3] zero
);
	import msq_pkg::*;

	tbl_req_t      req;
	logic [RW-1:0] rdata;
	logic [RW-1:0] square_count;

	// sequencer
	msq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_target (s_tdata[TW-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_count (square_count),
		.req       (req),
		.rdata     (rdata)
	);

	// count table
	msq_table u_table (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign m_tdata = {{(8 - RW){1'b0}}, square_count};

endmodule
